@@ hw/rtl/psde_pkg.sv @@
// package for the point set distance error statistics block
// widths, sequencer states and the shared unit request/response types
// no dependencies
package psde_pkg;

	localparam int COORD_W    = 24;
	localparam int MAG_W      = COORD_W;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int RAD_W      = SQ_W + 2;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int UNIT_W     = ROOT_W + 3;
	localparam int DIST_W     = 25;
	localparam int SUM_W      = 42;
	localparam int CNT_W      = 17;
	localparam int MAX_POINTS = 65536;
	localparam int STEP_W     = 6;
	localparam int IN_W       = 6 * COORD_W;
	localparam int OUT_FLD_W  = 2 * DIST_W + CNT_W + 1;
	localparam int OUT_W      = ((OUT_FLD_W + 7) / 8) * 8;

	localparam logic [CNT_W-1:0]  MAX_COUNT   = CNT_W'(MAX_POINTS);
	localparam logic [STEP_W-1:0] SQ_LAST     = STEP_W'(2);
	localparam logic [STEP_W-1:0] ROOT_LAST   = STEP_W'(ROOT_W - 1);
	localparam logic [STEP_W-1:0] DIV_LAST    = STEP_W'(SUM_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT,
		ST_UPDATE,
		ST_DIVIDE,
		ST_PUSH
	} state_t;

	typedef enum logic {
		OP_SQUARE,
		OP_TRIAL
	} unit_op_t;

	typedef struct packed {
		unit_op_t          op;
		logic [MAG_W-1:0]  mag;
		logic [UNIT_W-1:0] rem;
		logic [UNIT_W-1:0] trial;
	} unit_req_t;

	typedef struct packed {
		logic [SQ_W-1:0]   square;
		logic              ge;
		logic [UNIT_W-1:0] diff;
	} unit_rsp_t;

endpackage

@@ hw/rtl/psde_unit.sv @@
// shared arithmetic unit: squares a magnitude or does one trial subtract
// used by the square, root and divide steps; depends on psde_pkg
module psde_unit import psde_pkg::*; (
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	always_comb begin
		rsp = '0;
		case (req.op)
			OP_SQUARE: begin
				rsp.square = SQ_W'(req.mag) * SQ_W'(req.mag);
			end
			OP_TRIAL: begin
				rsp.ge   = (req.rem >= req.trial);
				rsp.diff = req.rem - req.trial;
			end
			default: begin
				rsp = '0;
			end
		endcase
	end

endmodule

@@ hw/rtl/point_set_distance_error_stats_core.sv @@
// top level of the point set distance error statistics block
// sequencer and registers around one shared unit; depends on psde_pkg, psde_unit
//
// usage:
// s_axis carries one pair of 3-d points per item (six signed 24-bit
// coordinates in tdata, tlast marks the final pair of a set). for each pair
// the block forms floor(sqrt(dx^2+dy^2+dz^2)) and folds it into a running
// sum, maximum and pair count. on the pair with tlast set it sends one item
// on m_axis with the mean distance, the maximum, the count and an overflow
// flag (pairs beyond 65536 are dropped), then clears its statistics.
// sequence: an item is taken, then each of the three magnitudes is squared through
// the shared multiplier, then 25 root steps of the shared subtractor and an
// update step follow for each pair. a last pair adds 42 divide steps on the
// same subtractor and a load of the output register, which waits until it is free.
// s_axis_tready is high only while the sequencer is idle.
// the result sits in an output register; while m_axis is stalled the block
// keeps taking pairs and only waits if a second result is ready to load.
// reset clears the sequencer, the statistics and the output valid.
module point_set_distance_error_stats_core import psde_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z
	input  logic [IN_W-1:0]  s_axis_tdata,
	input  logic             s_axis_tlast,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// mean_distance, max_distance, pair_count, count_overflow, zero fill
	output logic [OUT_W-1:0] m_axis_tdata
);

	state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic [MAG_W-1:0] mag_q [3];
	logic [RAD_W-1:0] rad_q;
	logic [UNIT_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic last_q;
	logic [SUM_W-1:0] sum_q;
	logic [DIST_W-1:0] max_q;
	logic [CNT_W-1:0] cnt_q;
	logic ovf_q;
	logic [SUM_W-1:0] quot_q;
	logic [OUT_W-1:0] out_q;
	logic out_valid_q;

	unit_req_t req;
	unit_rsp_t rsp;

	logic in_acc;
	logic push_ok;
	logic [MAG_W-1:0] mag_in [3];
	logic [DIST_W-1:0] pair_dist;
	logic [SUM_W:0] sum_add;
	logic [SUM_W-1:0] sum_upd;
	logic [DIST_W-1:0] max_upd;
	logic [CNT_W-1:0] cnt_upd;
	logic ovf_upd;
	logic [DIST_W-1:0] mean;

	psde_unit u_unit (
		.req(req),
		.rsp(rsp)
	);

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign push_ok = !out_valid_q || m_axis_tready;

	// coordinate magnitudes of the differences fit in COORD_W bits
	always_comb begin
		logic signed [COORD_W:0] a;
		logic signed [COORD_W:0] b;
		logic signed [COORD_W:0] d;
		for (int j = 0; j < 3; j++) begin
			a = (COORD_W+1)'($signed(s_axis_tdata[j*COORD_W +: COORD_W]));
			b = (COORD_W+1)'($signed(s_axis_tdata[(j+3)*COORD_W +: COORD_W]));
			d = a - b;
			mag_in[j] = d[COORD_W] ? MAG_W'(-d) : MAG_W'(d);
		end
	end

	// shared unit request
	always_comb begin
		req = '0;
		case (state_q)
			ST_SQUARE: begin
				req.op  = OP_SQUARE;
				req.mag = mag_q[step_q[1:0]];
			end
			ST_ROOT: begin
				req.op    = OP_TRIAL;
				req.rem   = {rem_q[UNIT_W-3:0], rad_q[RAD_W-1 -: 2]};
				req.trial = UNIT_W'({root_q, 2'b01});
			end
			ST_DIVIDE: begin
				req.op    = OP_TRIAL;
				req.rem   = UNIT_W'({rem_q[CNT_W-1:0], quot_q[SUM_W-1]});
				req.trial = UNIT_W'(cnt_q);
			end
			default: begin
				req = '0;
			end
		endcase
	end

	// statistics update for the pair just measured, and the mean of a finished set
	always_comb begin
		pair_dist = DIST_W'(root_q);
		sum_add   = {1'b0, sum_q} + (SUM_W+1)'(pair_dist);
		sum_upd   = sum_q;
		max_upd   = max_q;
		cnt_upd   = cnt_q;
		ovf_upd   = ovf_q;
		if (cnt_q >= MAX_COUNT) begin
			ovf_upd = 1'b1;
		end else begin
			cnt_upd = cnt_q + CNT_W'(1);
			sum_upd = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
			if (pair_dist > max_q) begin
				max_upd = pair_dist;
			end
		end
		mean = (cnt_q == '0) ? '0 : quot_q[DIST_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_SQUARE;
			end
			ST_SQUARE: begin
				if (step_q == SQ_LAST) state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (step_q == ROOT_LAST) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = last_q ? ST_DIVIDE : ST_IDLE;
			end
			ST_DIVIDE: begin
				if (step_q == DIV_LAST) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (push_ok) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		m_axis_tvalid = out_valid_q;
		m_axis_tdata  = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			sum_q       <= '0;
			max_q       <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// a new result loads in the same cycle the old one leaves
			if (state_q == ST_PUSH && push_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
				end
				ST_SQUARE, ST_ROOT, ST_DIVIDE: begin
					step_q <= (state_d == state_q) ? step_q + STEP_W'(1) : '0;
				end
				ST_UPDATE: begin
					step_q <= '0;
					sum_q  <= sum_upd;
					max_q  <= max_upd;
					cnt_q  <= cnt_upd;
					ovf_q  <= ovf_upd;
				end
				ST_PUSH: begin
					if (push_ok) begin
						sum_q <= '0;
						max_q <= '0;
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: begin
					step_q <= '0;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					mag_q  <= mag_in;
					last_q <= s_axis_tlast;
					rad_q  <= '0;
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			ST_SQUARE: begin
				rad_q <= rad_q + RAD_W'(rsp.square);
			end
			ST_ROOT: begin
				rad_q <= {rad_q[RAD_W-3:0], 2'b00};
				if (rsp.ge) begin
					rem_q  <= rsp.diff;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= req.rem;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			ST_UPDATE: begin
				// dividend and remainder for the mean of a finished set
				quot_q <= sum_upd;
				rem_q  <= '0;
			end
			ST_DIVIDE: begin
				quot_q <= {quot_q[SUM_W-2:0], rsp.ge};
				rem_q  <= rsp.ge ? rsp.diff : req.rem;
			end
			ST_PUSH: begin
				if (push_ok) begin
					out_q <= OUT_W'({ovf_q, cnt_q, max_q, mean});
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

endmodule

@@ tb/sv/tb.sv @@
// testbench for point_set_distance_error_stats_core: random and directed point pairs
// on s_axis, mean/max/count results checked on m_axis against an internal predictor
// depends on psde_pkg and the core rtl
module tb;
	import psde_pkg::*;

	localparam int    HALF_PERIOD  = 5;
	localparam int    RESET_CYCLES = 9;
	localparam int    QUIET_LIMIT  = 5000;
	localparam int    LONG_HOLD    = 1500;
	localparam int    DRAIN_CYCLES = 100;
	localparam int    RANDOM_PAIRS = 820;
	localparam int    CALM_PAIRS   = 100;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

	typedef struct {
		coord_t fx, fy, fz;
		coord_t sx, sy, sz;
		bit     last;
	} pair_t;

	typedef struct {
		bit [DIST_W-1:0] mean;
		bit [DIST_W-1:0] peak;
		bit [CNT_W-1:0]  count;
		bit              overflow;
	} stats_t;

	// predicts the per-set statistics and holds the results still to come
	class stats_tracker;
		stats_t          pending[$];
		bit [SUM_W-1:0]  dist_total;
		bit [DIST_W-1:0] dist_peak;
		bit [CNT_W-1:0]  pair_tally;
		bit              set_overflow;
		int              mismatches;
		int              results_seen;

		function bit [63:0] floor_sqrt(bit [63:0] v);
			bit [63:0] rem;
			bit [63:0] root;
			bit [63:0] trial;
			rem  = 0;
			root = 0;
			for (int i = 31; i >= 0; i--) begin
				rem   = (rem << 2) | ((v >> (2 * i)) & 64'd3);
				trial = (root << 2) | 64'd1;
				if (rem >= trial) begin
					rem  = rem - trial;
					root = (root << 1) | 64'd1;
				end else begin
					root = root << 1;
				end
			end
			return root;
		endfunction

		function bit [63:0] axis_gap(coord_t a, coord_t b);
			longint d;
			d = longint'(a) - longint'(b);
			return (d < 0) ? -d : d;
		endfunction

		function void take_pair(pair_t p);
			bit [63:0]       gx, gy, gz;
			bit [63:0]       root;
			bit [DIST_W-1:0] pair_dist;
			bit [63:0]       total;
			stats_t          r;
			gx   = axis_gap(p.fx, p.sx);
			gy   = axis_gap(p.fy, p.sy);
			gz   = axis_gap(p.fz, p.sz);
			root = floor_sqrt(gx * gx + gy * gy + gz * gz);
			pair_dist = (root > {DIST_W{1'b1}}) ? {DIST_W{1'b1}} : DIST_W'(root);
			// a full set drops the pair and only flags it
			if (pair_tally >= MAX_COUNT) begin
				set_overflow = 1'b1;
			end else begin
				pair_tally++;
				total      = 64'(dist_total) + 64'(pair_dist);
				dist_total = (total > {SUM_W{1'b1}}) ? {SUM_W{1'b1}} : SUM_W'(total);
				if (pair_dist > dist_peak)
					dist_peak = pair_dist;
			end
			if (p.last) begin
				total      = (pair_tally == 0) ? 64'd0 : 64'(dist_total) / 64'(pair_tally);
				r.mean     = DIST_W'(total);
				r.peak     = dist_peak;
				r.count    = pair_tally;
				r.overflow = set_overflow;
				pending.push_back(r);
				dist_total   = 0;
				dist_peak    = 0;
				pair_tally   = 0;
				set_overflow = 1'b0;
			end
		endfunction

		function void match_result(stats_t got);
			stats_t want;
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing expected: %0d %0d %0d %0d",
						$realtime, got.mean, got.peak, got.count, got.overflow);
				return;
			end
			want = pending.pop_front();
			if (got.mean != want.mean || got.peak != want.peak ||
			    got.count != want.count || got.overflow != want.overflow) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: mismatch: expected mean %0d max %0d count %0d ovf %0d",
						$realtime, want.mean, want.peak, want.count, want.overflow);
					$display("    got mean %0d max %0d count %0d ovf %0d",
						got.mean, got.peak, got.count, got.overflow);
				end
			end
		endfunction
	endclass

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata  = '0;
	logic              s_axis_tlast  = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;

	stats_tracker tracker = new();
	bit           tx_gaps;
	bit           rx_gaps;
	bit           hold_req;
	int           pairs_sent;
	int           quiet_cycles;

	point_set_distance_error_stats_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic coord_t pick_coord();
		int v;
		case ($urandom_range(0, 7))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return '0;
			3, 4: begin
				v = $urandom_range(0, 600);
				return coord_t'(v - 300);
			end
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic coord_t near(coord_t c);
		int v;
		v = $urandom_range(0, 2000);
		return c + coord_t'(v - 1000);
	endfunction

	function automatic pair_t random_pair(bit last);
		pair_t p;
		p.fx = pick_coord();
		p.fy = pick_coord();
		p.fz = pick_coord();
		// point sets under test are mostly close to each other
		if ($urandom_range(0, 2) != 0) begin
			p.sx = near(p.fx);
			p.sy = near(p.fy);
			p.sz = near(p.fz);
		end else begin
			p.sx = pick_coord();
			p.sy = pick_coord();
			p.sz = pick_coord();
		end
		p.last = last;
		return p;
	endfunction

	function automatic pair_t make_pair(coord_t fx, coord_t fy, coord_t fz,
	                                    coord_t sx, coord_t sy, coord_t sz, bit last);
		pair_t p;
		p.fx   = fx;
		p.fy   = fy;
		p.fz   = fz;
		p.sx   = sx;
		p.sy   = sy;
		p.sz   = sz;
		p.last = last;
		return p;
	endfunction

	task automatic send_pair(pair_t p);
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {p.sz, p.sy, p.sx, p.fz, p.fy, p.fx};
		s_axis_tlast  <= p.last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		tracker.take_pair(p);
		pairs_sent++;
	endtask

	task automatic send_set(int n);
		for (int i = 0; i < n; i++)
			send_pair(random_pair(i == n - 1));
	endtask

	// result side: random stall bursts plus one long hold on request
	initial begin
		stats_t got;
		int     stall_left;
		int     hold_left;
		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.mean     = m_axis_tdata[DIST_W-1:0];
				got.peak     = m_axis_tdata[2*DIST_W-1:DIST_W];
				got.count    = m_axis_tdata[2*DIST_W+CNT_W-1:2*DIST_W];
				got.overflow = m_axis_tdata[2*DIST_W+CNT_W];
				tracker.match_result(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD - 1;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles in which neither side moves an item
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $realtime, QUIET_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int n;
		int random_start;
		bit pressed;
		tx_gaps  = 1'b0;
		rx_gaps  = 1'b0;
		hold_req = 1'b0;
		pressed  = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero distance, extreme spans in both directions, a known triangle
		send_pair(make_pair('0, '0, '0, '0, '0, '0, 1'b1));
		send_pair(make_pair(COORD_MIN, COORD_MIN, COORD_MIN,
		                    COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
		send_pair(make_pair(COORD_MAX, COORD_MAX, COORD_MAX,
		                    COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
		send_pair(make_pair(COORD_MAX, '0, COORD_MIN, COORD_MIN, '0, COORD_MAX, 1'b0));
		send_pair(make_pair(coord_t'(768), coord_t'(1024), '0, '0, '0, '0, 1'b0));
		send_pair(make_pair('0, '0, '0, '0, '0, coord_t'(-1), 1'b0));
		send_pair(make_pair(COORD_MIN, COORD_MAX, '0, COORD_MIN, COORD_MAX, '0, 1'b1));
		send_pair(make_pair(coord_t'(1), coord_t'(1), coord_t'(1), '0, '0, '0, 1'b0));
		send_pair(make_pair(coord_t'(-2), coord_t'(3), coord_t'(-5),
		                    coord_t'(7), coord_t'(-11), coord_t'(13), 1'b1));
		for (int i = 0; i < 6; i++)
			send_pair(random_pair(i == 5));

		random_start = pairs_sent;
		while (pairs_sent - random_start < RANDOM_PAIRS) begin
			if (pairs_sent - random_start >= RANDOM_PAIRS - CALM_PAIRS) begin
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end else begin
				tx_gaps = ($urandom_range(0, 3) != 0);
				rx_gaps = ($urandom_range(0, 3) != 0);
			end
			if (!pressed && pairs_sent - random_start >= RANDOM_PAIRS / 3) begin
				// results back up behind a stalled receiver until the input stalls
				pressed  = 1'b1;
				tx_gaps  = 1'b0;
				hold_req = 1'b1;
				for (int i = 0; i < 5; i++)
					send_set(2);
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
			send_set(n);
		end
		s_axis_tvalid <= 1'b0;
		s_axis_tlast  <= 1'b0;

		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.pending.size() != 0)
			tracker.mismatches += tracker.pending.size();
		$display("sent %0d point pairs, checked %0d set results, %0d mismatches",
			pairs_sent, tracker.results_seen, tracker.mismatches);
		$display("covered extreme spans, sets of many lengths, random idling and a long output stall");
		if (tracker.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ point_set_distance_error_stats_core.f @@
hw/rtl/psde_pkg.sv
hw/rtl/psde_unit.sv
hw/rtl/point_set_distance_error_stats_core.sv
tb/sv/tb.sv
